@@ rtl/core/cer_pkg.sv @@
// Shared types, constants and codes for the coalescing pointer-event ring.
package cer_pkg;

    // Ring geometry
    localparam int RING_DEPTH = 64;
    localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    // Request codes
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // Event kind codes
    localparam logic [1:0] KIND_MOTION = 2'd0;
    localparam logic [1:0] KIND_BUTTON = 2'd1;
    localparam logic [1:0] KIND_WHEEL  = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    // Input beat
    typedef struct packed {
        logic               req_type;
        logic [1:0]         event_kind;
        logic signed [15:0] move_x;
        logic signed [15:0] move_y;
        logic [7:0]         button_id;
        logic               pressed;
        logic signed [15:0] scroll_x;
        logic signed [15:0] scroll_y;
    } t_req_item;

    // Result beat
    typedef struct packed {
        logic               got;
        logic [1:0]         out_kind;
        logic signed [15:0] out_move_x;
        logic signed [15:0] out_move_y;
        logic [7:0]         out_button_id;
        logic               out_pressed;
        logic signed [15:0] out_scroll_x;
        logic signed [15:0] out_scroll_y;
    } t_result_item;

    // One ring slot: kind plus packed payload
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] payload;
    } t_slot;

    // Controller to datapath commands
    typedef struct packed {
        logic push;
        logic pop;
        logic emit;
    } t_cer_cmd;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_cer_state;

endpackage

@@ rtl/core/cer_ctrl.sv @@
// Controller state machine: accepts requests and sequences pop responses.
module cer_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_req_type,
    output logic              o_busy,
    output cer_pkg::t_cer_cmd o_cmd
);
    import cer_pkg::*;

    t_cer_state r_state;
    t_cer_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: a pop moves to ST_EMIT to present its result, then back to ST_IDLE
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start && (i_req_type == REQ_POP)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs: issue commands to the datapath
    always_comb begin
        o_busy   = 1'b0;
        o_cmd    = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.push = i_start && (i_req_type == REQ_PUSH);
                o_cmd.pop  = i_start && (i_req_type == REQ_POP);
            end
            ST_EMIT: begin
                o_busy     = 1'b1;
                o_cmd.emit = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

@@ rtl/core/cer_dpath.sv @@
// Datapath: slot memory, ring pointers, newest-entry copy and motion merge.
module cer_dpath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cer_pkg::t_cer_cmd     i_cmd,
    input  cer_pkg::t_req_item    i_req,
    output cer_pkg::t_result_item o_result
);
    import cer_pkg::*;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);

    t_slot mem [RING_DEPTH];

    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [1:0]       r_last_kind;
    logic [31:0]      r_last_payload;
    logic             r_got;
    t_slot            r_rd_slot;

    logic             empty;
    logic [PTR_W-1:0] wr_next;
    logic [PTR_W-1:0] wr_prev;
    logic [PTR_W-1:0] rd_next;
    logic             merge;
    logic             store;
    logic [15:0]      sum_x;
    logic [15:0]      sum_y;
    logic [31:0]      new_payload;
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    t_slot            wr_slot;

    // Saturating 16-bit signed add
    function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
        logic signed [16:0] s;
        s = $signed({a[15], a}) + $signed({b[15], b});
        if (s > 17'sd32767) begin
            return 16'h7FFF;
        end else if (s < -17'sd32768) begin
            return 16'h8000;
        end else begin
            return s[15:0];
        end
    endfunction

    // Pointer arithmetic
    assign empty   = (r_rd_ptr == r_wr_ptr);
    assign wr_next = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_ONE;
    assign wr_prev = (r_wr_ptr == '0) ? PTR_LAST : r_wr_ptr - PTR_ONE;
    assign rd_next = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_ONE;

    // Merge motion into the newest entry when it is motion, otherwise take a new slot (KIND_NONE stores nothing)
    assign merge = i_cmd.push && (i_req.event_kind == KIND_MOTION) && !empty
                   && (r_last_kind == KIND_MOTION);
    assign store = i_cmd.push && (i_req.event_kind != KIND_NONE) && !merge;

    assign sum_x = sat_add16(r_last_payload[15:0], i_req.move_x);
    assign sum_y = sat_add16(r_last_payload[31:16], i_req.move_y);

    // Pack the payload of a fresh entry
    always_comb begin
        case (i_req.event_kind)
            KIND_MOTION: new_payload = {i_req.move_y, i_req.move_x};
            KIND_BUTTON: new_payload = {23'd0, i_req.pressed, i_req.button_id};
            default:     new_payload = {i_req.scroll_y, i_req.scroll_x};
        endcase
    end

    // Single write port: merged entry or new slot
    assign wr_en        = merge || store;
    assign wr_addr      = merge ? wr_prev : r_wr_ptr;
    assign wr_slot.kind = merge ? KIND_MOTION : i_req.event_kind;
    assign wr_slot.payload = merge ? {sum_y, sum_x} : new_payload;

    // Pointer next values: drop oldest when full, advance on pop
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (store) begin
            n_wr_ptr = wr_next;
            if (wr_next == r_rd_ptr) begin
                n_rd_ptr = rd_next;
            end
        end else if (i_cmd.pop && !empty) begin
            n_rd_ptr = rd_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_got    <= 1'b0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            if (i_cmd.pop) begin
                r_got <= !empty;
            end
        end
    end

    // Slot memory write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_slot;
        end
        if (i_cmd.pop) begin
            r_rd_slot <= mem[r_rd_ptr];
        end
    end

    // Keep a copy of the newest entry for merging
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_kind <= KIND_NONE;
        end else if (wr_en) begin
            r_last_kind <= wr_slot.kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_last_payload <= wr_slot.payload;
        end
    end

    // Unpack the popped beat, zeroing fields of other kinds
    always_comb begin
        o_result = '0;
        if (i_cmd.emit && r_got) begin
            o_result.got      = 1'b1;
            o_result.out_kind = r_rd_slot.kind;
            case (r_rd_slot.kind)
                KIND_MOTION: begin
                    o_result.out_move_x = r_rd_slot.payload[15:0];
                    o_result.out_move_y = r_rd_slot.payload[31:16];
                end
                KIND_BUTTON: begin
                    o_result.out_button_id = r_rd_slot.payload[7:0];
                    o_result.out_pressed   = r_rd_slot.payload[8];
                end
                default: begin
                    o_result.out_scroll_x = r_rd_slot.payload[15:0];
                    o_result.out_scroll_y = r_rd_slot.payload[31:16];
                end
            endcase
        end
    end

endmodule

@@ rtl/core/coalescing_event_ring.sv @@
// Pushes do not raise busy: a new request may follow in the next cycle.
// Pops: the slot memory read is registered, so the result
// strobe o_result_valid rises the cycle after the pop is accepted, busy high then.
// The receiver cannot stall; each result stands for exactly one cycle.
// Synchronous active-low reset empties the ring (both pointers to zero);
// slot contents are not cleared.
module coalescing_event_ring (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  cer_pkg::t_req_item    i_req,
    output logic                  o_result_valid,
    output cer_pkg::t_result_item o_result
);
    import cer_pkg::*;

    t_cer_cmd cmd;

    // Sequence requests
    cer_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req.req_type),
        .o_busy     (busy),
        .o_cmd      (cmd)
    );

    // Ring storage and merge logic
    cer_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_req    (i_req),
        .o_result (o_result)
    );

    assign o_result_valid = cmd.emit;

endmodule
